// File: design/hpbp_pkg.sv
// Shared types and constants for the HPACK header block parser.
package hpbp_pkg;

    localparam int IntBits = 28;
    localparam int ValueW  = 28;
    localparam int ShiftW  = $clog2(IntBits);
    localparam int SumW    = IntBits + 8;

    localparam logic [6:0] MaskIdx  = 7'h7F;
    localparam logic [6:0] MaskInc  = 7'h3F;
    localparam logic [6:0] MaskSize = 7'h1F;
    localparam logic [6:0] MaskLit  = 7'h0F;

    localparam logic [1:0] ErrZero     = 2'd0;
    localparam logic [1:0] ErrOverflow = 2'd1;
    localparam logic [1:0] ErrTrunc    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HDR_INT  = 3'd1,
        PH_STR_HDR  = 3'd2,
        PH_STR_INT  = 3'd3,
        PH_STR_DATA = 3'd4,
        PH_DRAIN    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        REPR_INDEXED = 3'd0,
        REPR_INCR    = 3'd1,
        REPR_WITHOUT = 3'd2,
        REPR_NEVER   = 3'd3,
        REPR_SIZE    = 3'd4
    } repr_t;

    typedef enum logic [2:0] {
        EV_INDEXED   = 3'd0,
        EV_LITERAL   = 3'd1,
        EV_STR_START = 3'd2,
        EV_STR_BYTE  = 3'd3,
        EV_SIZE      = 3'd4,
        EV_ERROR     = 3'd5
    } ev_t;

    typedef struct packed {
        phase_t               phase;
        logic [IntBits-1:0]   accum;
        logic [ShiftW-1:0]    shift;
        repr_t                repr;
        logic [IntBits-1:0]   bytes_left;
        logic                 name_pending;
        logic                 huff;
    } state_t;

    typedef struct packed {
        ev_t                  ev;
        logic [ValueW-1:0]    value;
        logic [1:0]           repr_kind;
        logic                 huff;
        logic                 is_name;
        logic [7:0]           data;
        logic                 last;
        logic                 done;
    } result_t;

endpackage

// File: design/hpbp_step.sv
// Next-state and event logic for one header block octet.
module hpbp_step (
    input  hpbp_pkg::state_t  st_i,
    input  logic [7:0]        byte_i,
    input  logic              eob_i,
    output hpbp_pkg::state_t  st_o,
    output logic              fire_o,
    output hpbp_pkg::result_t res_o
);

    hpbp_pkg::state_t              nxt;
    hpbp_pkg::result_t             res;
    logic                          fire;
    logic                          raise;
    logic [1:0]                    code;
    logic                          do_hdr;
    logic                          do_len;
    logic [hpbp_pkg::IntBits-1:0]  int_val;
    logic [6:0]                    mask;
    logic [6:0]                    pre;
    hpbp_pkg::repr_t               repr;
    logic [hpbp_pkg::SumW-1:0]     sum;
    logic [hpbp_pkg::ShiftW:0]     shift_p7;
    logic                          int_ovf;
    logic                          int_more;
    logic                          was_name;
    logic [1:0]                    kind;
    logic                          last;
    logic [hpbp_pkg::IntBits-1:0]  left_dec;

    always_comb begin
        sum = hpbp_pkg::SumW'(st_i.accum)
            + (hpbp_pkg::SumW'(byte_i[6:0]) << st_i.shift);
        shift_p7 = {1'b0, st_i.shift} + (hpbp_pkg::ShiftW+1)'(7);
        int_ovf = ((hpbp_pkg::ShiftW+1)'({1'b0, st_i.shift}) >=
                   (hpbp_pkg::ShiftW+1)'(hpbp_pkg::IntBits))
               || (sum[hpbp_pkg::SumW-1:hpbp_pkg::IntBits] != '0)
               || (byte_i[7] && (shift_p7 >= (hpbp_pkg::ShiftW+1)'(hpbp_pkg::IntBits)));
        int_more = byte_i[7];

        if (byte_i[7]) begin
            repr = hpbp_pkg::REPR_INDEXED; mask = hpbp_pkg::MaskIdx;
        end else if (byte_i[7:6] == 2'b01) begin
            repr = hpbp_pkg::REPR_INCR;    mask = hpbp_pkg::MaskInc;
        end else if (byte_i[7:5] == 3'b001) begin
            repr = hpbp_pkg::REPR_SIZE;    mask = hpbp_pkg::MaskSize;
        end else if (byte_i[7:4] == 4'b0001) begin
            repr = hpbp_pkg::REPR_NEVER;   mask = hpbp_pkg::MaskLit;
        end else begin
            repr = hpbp_pkg::REPR_WITHOUT; mask = hpbp_pkg::MaskLit;
        end
        pre = byte_i[6:0] & mask;
    end

    always_comb begin
        nxt      = st_i;
        res      = '0;
        fire     = 1'b0;
        raise    = 1'b0;
        code     = hpbp_pkg::ErrZero;
        do_hdr   = 1'b0;
        do_len   = 1'b0;
        int_val  = '0;
        was_name = st_i.name_pending;
        last     = 1'b0;
        left_dec = st_i.bytes_left;

        unique case (st_i.phase)
            hpbp_pkg::PH_IDLE: begin
                nxt.repr = repr;
                if (pre != mask) begin
                    do_hdr  = 1'b1;
                    int_val = hpbp_pkg::IntBits'(pre);
                end else begin
                    nxt.accum = hpbp_pkg::IntBits'(mask);
                    nxt.shift = '0;
                    nxt.phase = hpbp_pkg::PH_HDR_INT;
                    if (eob_i) begin raise = 1'b1; code = hpbp_pkg::ErrTrunc; end
                end
            end
            hpbp_pkg::PH_HDR_INT, hpbp_pkg::PH_STR_INT: begin
                if (int_ovf) begin
                    raise = 1'b1;
                    code  = hpbp_pkg::ErrOverflow;
                end else if (int_more) begin
                    nxt.accum = sum[hpbp_pkg::IntBits-1:0];
                    nxt.shift = shift_p7[hpbp_pkg::ShiftW-1:0];
                    if (eob_i) begin raise = 1'b1; code = hpbp_pkg::ErrTrunc; end
                end else begin
                    int_val = sum[hpbp_pkg::IntBits-1:0];
                    if (st_i.phase == hpbp_pkg::PH_STR_INT) do_len = 1'b1;
                    else do_hdr = 1'b1;
                end
            end
            hpbp_pkg::PH_STR_HDR: begin
                nxt.huff = byte_i[7];
                if (byte_i[6:0] != 7'h7F) begin
                    do_len  = 1'b1;
                    int_val = hpbp_pkg::IntBits'(byte_i[6:0]);
                end else begin
                    nxt.accum = hpbp_pkg::IntBits'(7'h7F);
                    nxt.shift = '0;
                    nxt.phase = hpbp_pkg::PH_STR_INT;
                    if (eob_i) begin raise = 1'b1; code = hpbp_pkg::ErrTrunc; end
                end
            end
            hpbp_pkg::PH_STR_DATA: begin
                if (st_i.bytes_left != '0) left_dec = st_i.bytes_left - 1'b1;
                nxt.bytes_left = left_dec;
                last = (left_dec == '0);
                if (last) begin
                    if (st_i.name_pending) begin
                        nxt.name_pending = 1'b0;
                        nxt.phase        = hpbp_pkg::PH_STR_HDR;
                    end else begin
                        nxt.phase = hpbp_pkg::PH_IDLE;
                    end
                end
                if (eob_i && nxt.phase != hpbp_pkg::PH_IDLE) begin
                    raise = 1'b1; code = hpbp_pkg::ErrTrunc;
                end else begin
                    fire    = 1'b1;
                    res.ev  = hpbp_pkg::EV_STR_BYTE;
                    res.huff    = st_i.huff;
                    res.is_name = was_name;
                    res.data    = byte_i;
                    res.last    = last;
                    res.done    = eob_i;
                end
            end
            default: begin
                nxt.phase = eob_i ? hpbp_pkg::PH_IDLE : hpbp_pkg::PH_DRAIN;
            end
        endcase

        if (do_hdr) begin
            nxt.accum = '0;
            nxt.shift = '0;
            if (nxt.repr == hpbp_pkg::REPR_INDEXED) begin
                if (int_val == '0) begin
                    raise = 1'b1; code = hpbp_pkg::ErrZero;
                end else begin
                    nxt.phase = hpbp_pkg::PH_IDLE;
                    fire      = 1'b1;
                    res.ev    = hpbp_pkg::EV_INDEXED;
                    res.value = hpbp_pkg::ValueW'(int_val);
                    res.done  = eob_i;
                end
            end else if (nxt.repr == hpbp_pkg::REPR_SIZE) begin
                nxt.phase = hpbp_pkg::PH_IDLE;
                fire      = 1'b1;
                res.ev    = hpbp_pkg::EV_SIZE;
                res.value = hpbp_pkg::ValueW'(int_val);
                res.done  = eob_i;
            end else begin
                nxt.name_pending = (int_val == '0);
                nxt.phase        = hpbp_pkg::PH_STR_HDR;
                if (eob_i) begin
                    raise = 1'b1; code = hpbp_pkg::ErrTrunc;
                end else begin
                    fire      = 1'b1;
                    res.ev    = hpbp_pkg::EV_LITERAL;
                    res.value = hpbp_pkg::ValueW'(int_val);
                end
            end
        end

        if (do_len) begin
            nxt.accum      = '0;
            nxt.shift      = '0;
            nxt.bytes_left = int_val;
            if (int_val == '0) begin
                if (st_i.name_pending) begin
                    nxt.name_pending = 1'b0;
                    nxt.phase        = hpbp_pkg::PH_STR_HDR;
                end else begin
                    nxt.phase = hpbp_pkg::PH_IDLE;
                end
            end else begin
                nxt.phase = hpbp_pkg::PH_STR_DATA;
            end
            if (eob_i && nxt.phase != hpbp_pkg::PH_IDLE) begin
                raise = 1'b1; code = hpbp_pkg::ErrTrunc;
            end else begin
                fire        = 1'b1;
                res.ev      = hpbp_pkg::EV_STR_START;
                res.value   = hpbp_pkg::ValueW'(int_val);
                res.huff    = nxt.huff;
                res.is_name = was_name;
                res.last    = (int_val == '0);
                res.done    = eob_i;
            end
        end

        kind = (nxt.repr == hpbp_pkg::REPR_INCR || nxt.repr == hpbp_pkg::REPR_WITHOUT ||
                nxt.repr == hpbp_pkg::REPR_NEVER) ? 2'(nxt.repr - 3'd1) : 2'd0;
        if (res.ev == hpbp_pkg::EV_LITERAL || res.ev == hpbp_pkg::EV_STR_START ||
            res.ev == hpbp_pkg::EV_STR_BYTE) begin
            res.repr_kind = kind;
        end

        if (raise) begin
            nxt.phase        = eob_i ? hpbp_pkg::PH_IDLE : hpbp_pkg::PH_DRAIN;
            nxt.accum        = '0;
            nxt.shift        = '0;
            nxt.bytes_left   = '0;
            nxt.name_pending = 1'b0;
            fire             = 1'b1;
            res              = '0;
            res.ev           = hpbp_pkg::EV_ERROR;
            res.value        = hpbp_pkg::ValueW'(code);
            res.done         = eob_i;
        end
    end

    assign st_o   = nxt;
    assign fire_o = fire;
    assign res_o  = res;

endmodule

// File: design/hpack_header_block_parser_unit.sv
// HPACK header block parser top level: parser state, result register, handshakes.
// Takes one octet of an HPACK header block per clock cycle and gives at most one
// event per octet, in the cycle after the octet's transfer, held in a result register;
// the next octet is taken in the same cycle as long as that register is empty or is
// being read. The rate is set by the combinational update of the parser state
// (prefix integer add and compare, representation decode). Huffman strings and
// table indices are passed through undecoded. No start-up pass after reset.
module hpack_header_block_parser_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_byte_in,
    input  logic                          s_end_of_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_res,
    output logic [hpbp_pkg::ValueW-1:0]   m_value,
    output logic [1:0]                    m_repr_kind,
    output logic                          m_huffman_flag,
    output logic                          m_is_name,
    output logic [7:0]                    m_data_byte,
    output logic                          m_last_of_string,
    output logic                          m_block_done
);

    hpbp_pkg::state_t  st_reg;
    hpbp_pkg::state_t  st_next;
    hpbp_pkg::result_t res_reg;
    hpbp_pkg::result_t res_next;
    logic              m_valid_reg;
    logic              fire;
    logic              s_xfer;

    hpbp_step u_step (
        .st_i   (st_reg),
        .byte_i (s_byte_in),
        .eob_i  (s_end_of_block),
        .st_o   (st_next),
        .fire_o (fire),
        .res_o  (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // all-zero state is phase idle
            st_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_xfer) begin
                st_reg <= st_next;
            end
            if (s_xfer && fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_res      = res_reg.ev;
    assign m_value          = res_reg.value;
    assign m_repr_kind      = res_reg.repr_kind;
    assign m_huffman_flag   = res_reg.huff;
    assign m_is_name        = res_reg.is_name;
    assign m_data_byte      = res_reg.data;
    assign m_last_of_string = res_reg.last;
    assign m_block_done     = res_reg.done;

    // block end always leaves the parser idle
    a_eob_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_block |=> st_reg.phase == hpbp_pkg::PH_IDLE)
        else $error("parser not idle after block end");

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase == hpbp_pkg::PH_STR_DATA |-> st_reg.bytes_left != '0)
        else $error("string data phase with no bytes left");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == hpbp_pkg::EV_ERROR |->
            m_repr_kind == 2'd0 && !m_is_name && m_data_byte == 8'd0 && !m_last_of_string)
        else $error("error event carries string fields");

    a_last_str: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_string |->
            m_event_res == hpbp_pkg::EV_STR_START || m_event_res == hpbp_pkg::EV_STR_BYTE)
        else $error("last_of_string on non-string event");

endmodule

// File: tb/tb_hpack_header_block_parser_unit.sv
// Self-checking testbench for the HPACK header block parser unit.
`timescale 1ns / 1ps

module tb_hpack_header_block_parser_unit;

    localparam int StallLimit = 5000;
    localparam int NumOctets  = 1950;
    localparam int HoldCycles = 400;
    localparam longint unsigned IntMax = (64'd1 << hpbp_pkg::IntBits) - 1;

    localparam logic [7:0] PfxIndexed = 8'h80;
    localparam logic [7:0] PfxIncr    = 8'h40;
    localparam logic [7:0] PfxSize    = 8'h20;
    localparam logic [7:0] PfxNever   = 8'h10;
    localparam logic [7:0] PfxWithout = 8'h00;

    typedef enum logic [1:0] {INT_MORE, INT_DONE, INT_OVER} int_rc_t;

    typedef struct packed {
        logic [7:0]        b;
        logic              eob;
        logic              pinned;
        hpbp_pkg::result_t res;
    } octet_t;

    typedef struct packed {
        logic [7:0]                  b;
        logic                        eob;
        logic                        pinned;
        hpbp_pkg::ev_t               ev;
        logic [hpbp_pkg::ValueW-1:0] val;
    } row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_byte_in;
    logic                        s_end_of_block;
    logic                        m_valid;
    logic                        m_ready;
    logic [2:0]                  m_event_res;
    logic [hpbp_pkg::ValueW-1:0] m_value;
    logic [1:0]                  m_repr_kind;
    logic                        m_huffman_flag;
    logic                        m_is_name;
    logic [7:0]                  m_data_byte;
    logic                        m_last_of_string;
    logic                        m_block_done;

    logic              pin_now;
    hpbp_pkg::result_t pin_res;
    logic              calm;

    octet_t            feed_q[$];
    logic [7:0]        blk_q[$];
    hpbp_pkg::result_t event_q[$];

    int sent       = 0;
    int blocks     = 0;
    int checked    = 0;
    int mismatches = 0;
    int stall_cnt  = 0;
    int ev_seen[8] = '{default: 0};

    // parser state mirror
    hpbp_pkg::phase_t p_phase    = hpbp_pkg::PH_IDLE;
    longint unsigned  p_accum    = 0;
    int unsigned      p_shift    = 0;
    hpbp_pkg::repr_t  p_repr     = hpbp_pkg::REPR_INDEXED;
    longint unsigned  p_left     = 0;
    bit               p_name_due = 1'b0;
    bit               p_huff     = 1'b0;

    row_t directed_rows [27] = '{
        '{8'h80, 1'b1, 1'b1, hpbp_pkg::EV_ERROR,   28'(hpbp_pkg::ErrZero)},
        '{8'h81, 1'b0, 1'b1, hpbp_pkg::EV_INDEXED, 28'd1},
        // largest index that fits
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h80, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h7F, 1'b0, 1'b1, hpbp_pkg::EV_INDEXED, 28'hFFFFFFF},
        // overflow, then discard to end of block
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hFF, 1'b0, 1'b1, hpbp_pkg::EV_ERROR,   28'(hpbp_pkg::ErrOverflow)},
        '{8'h00, 1'b1, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        // incremental, new name, Huffman name, empty value
        '{8'h40, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h82, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h61, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h62, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h00, 1'b1, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        // never indexed, saturated name index
        '{8'h1F, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h01, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h01, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'hAA, 1'b1, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        // without indexing
        '{8'h05, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h00, 1'b1, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        // size update
        '{8'h3F, 1'b0, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        '{8'h00, 1'b1, 1'b0, hpbp_pkg::EV_INDEXED, 28'd0},
        // block ends on a literal header
        '{8'h41, 1'b1, 1'b1, hpbp_pkg::EV_ERROR,   28'(hpbp_pkg::ErrTrunc)}
    };

    hpack_header_block_parser_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_end_of_block   (s_end_of_block),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_value          (m_value),
        .m_repr_kind      (m_repr_kind),
        .m_huffman_flag   (m_huffman_flag),
        .m_is_name        (m_is_name),
        .m_data_byte      (m_data_byte),
        .m_last_of_string (m_last_of_string),
        .m_block_done     (m_block_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    assign calm = (sent >= 900) && (sent < 1250);

    function automatic hpbp_pkg::result_t ev_pack(hpbp_pkg::ev_t ev, longint unsigned v,
                                                  logic done);
        hpbp_pkg::result_t r;
        r       = '0;
        r.ev    = ev;
        r.value = v[hpbp_pkg::ValueW-1:0];
        r.done  = done;
        return r;
    endfunction

    function automatic logic [1:0] lit_kind();
        case (p_repr)
            hpbp_pkg::REPR_WITHOUT: return 2'd1;
            hpbp_pkg::REPR_NEVER:   return 2'd2;
            default:                return 2'd0;
        endcase
    endfunction

    function automatic hpbp_pkg::result_t fail_with(logic [1:0] code, logic eob);
        if (eob) p_phase = hpbp_pkg::PH_IDLE;
        else p_phase = hpbp_pkg::PH_DRAIN;
        p_accum    = 0;
        p_shift    = 0;
        p_left     = 0;
        p_name_due = 1'b0;
        return ev_pack(hpbp_pkg::EV_ERROR, code, eob);
    endfunction

    function automatic int_rc_t int_step(logic [7:0] b);
        longint unsigned sum;
        if (p_shift >= hpbp_pkg::IntBits) return INT_OVER;
        sum = p_accum + (longint'(b[6:0]) << p_shift);
        if (sum > IntMax) return INT_OVER;
        p_accum = sum;
        if (!b[7]) return INT_DONE;
        if (p_shift + 7 >= hpbp_pkg::IntBits) return INT_OVER;
        p_shift += 7;
        return INT_MORE;
    endfunction

    function automatic void string_done();
        if (p_name_due) begin
            p_name_due = 1'b0;
            p_phase    = hpbp_pkg::PH_STR_HDR;
        end else begin
            p_phase = hpbp_pkg::PH_IDLE;
        end
    endfunction

    function automatic hpbp_pkg::result_t finish_header(longint unsigned v, logic eob);
        hpbp_pkg::result_t r;
        p_accum = 0;
        p_shift = 0;
        if (p_repr == hpbp_pkg::REPR_INDEXED) begin
            if (v == 0) return fail_with(hpbp_pkg::ErrZero, eob);
            p_phase = hpbp_pkg::PH_IDLE;
            return ev_pack(hpbp_pkg::EV_INDEXED, v, eob);
        end
        if (p_repr == hpbp_pkg::REPR_SIZE) begin
            p_phase = hpbp_pkg::PH_IDLE;
            return ev_pack(hpbp_pkg::EV_SIZE, v, eob);
        end
        p_name_due = (v == 0);
        p_phase    = hpbp_pkg::PH_STR_HDR;
        if (eob) return fail_with(hpbp_pkg::ErrTrunc, eob);
        r           = ev_pack(hpbp_pkg::EV_LITERAL, v, 1'b0);
        r.repr_kind = lit_kind();
        return r;
    endfunction

    function automatic hpbp_pkg::result_t finish_length(longint unsigned len, logic eob);
        hpbp_pkg::result_t r;
        bit                was_name;
        was_name = p_name_due;
        p_accum  = 0;
        p_shift  = 0;
        p_left   = len;
        if (len == 0) string_done();
        else p_phase = hpbp_pkg::PH_STR_DATA;
        if (eob && p_phase != hpbp_pkg::PH_IDLE) return fail_with(hpbp_pkg::ErrTrunc, eob);
        r           = ev_pack(hpbp_pkg::EV_STR_START, len, eob);
        r.repr_kind = lit_kind();
        r.huff      = p_huff;
        r.is_name   = was_name;
        r.last      = (len == 0);
        return r;
    endfunction

    // Advances the parser mirror by one octet; returns 1 when an event is due.
    function automatic bit parse_octet(input logic [7:0] b, input logic eob,
                                       output hpbp_pkg::result_t r);
        logic [7:0] mask;
        bit         was_name;
        int_rc_t    rc;
        r = '0;
        case (p_phase)
            hpbp_pkg::PH_IDLE: begin
                if (b[7]) begin
                    p_repr = hpbp_pkg::REPR_INDEXED;
                    mask   = {1'b0, hpbp_pkg::MaskIdx};
                end else if (b[7:6] == 2'b01) begin
                    p_repr = hpbp_pkg::REPR_INCR;
                    mask   = {1'b0, hpbp_pkg::MaskInc};
                end else if (b[7:5] == 3'b001) begin
                    p_repr = hpbp_pkg::REPR_SIZE;
                    mask   = {1'b0, hpbp_pkg::MaskSize};
                end else if (b[7:4] == 4'b0001) begin
                    p_repr = hpbp_pkg::REPR_NEVER;
                    mask   = {1'b0, hpbp_pkg::MaskLit};
                end else begin
                    p_repr = hpbp_pkg::REPR_WITHOUT;
                    mask   = {1'b0, hpbp_pkg::MaskLit};
                end
                if ((b & mask) != mask) begin
                    r = finish_header(b & mask, eob);
                    return 1'b1;
                end
                p_accum = mask;
                p_shift = 0;
                p_phase = hpbp_pkg::PH_HDR_INT;
                if (!eob) return 1'b0;
                r = fail_with(hpbp_pkg::ErrTrunc, eob);
                return 1'b1;
            end
            hpbp_pkg::PH_STR_HDR: begin
                p_huff = b[7];
                if (b[6:0] != 7'h7F) begin
                    r = finish_length(b[6:0], eob);
                    return 1'b1;
                end
                p_accum = 7'h7F;
                p_shift = 0;
                p_phase = hpbp_pkg::PH_STR_INT;
                if (!eob) return 1'b0;
                r = fail_with(hpbp_pkg::ErrTrunc, eob);
                return 1'b1;
            end
            hpbp_pkg::PH_HDR_INT, hpbp_pkg::PH_STR_INT: begin
                rc = int_step(b);
                if (rc == INT_OVER) begin
                    r = fail_with(hpbp_pkg::ErrOverflow, eob);
                end else if (rc == INT_MORE) begin
                    if (!eob) return 1'b0;
                    r = fail_with(hpbp_pkg::ErrTrunc, eob);
                end else if (p_phase == hpbp_pkg::PH_STR_INT) begin
                    r = finish_length(p_accum, eob);
                end else begin
                    r = finish_header(p_accum, eob);
                end
                return 1'b1;
            end
            hpbp_pkg::PH_STR_DATA: begin
                was_name = p_name_due;
                if (p_left > 0) p_left--;
                if (p_left == 0) string_done();
                if (eob && p_phase != hpbp_pkg::PH_IDLE) begin
                    r = fail_with(hpbp_pkg::ErrTrunc, eob);
                    return 1'b1;
                end
                r           = ev_pack(hpbp_pkg::EV_STR_BYTE, 0, eob);
                r.repr_kind = lit_kind();
                r.huff      = p_huff;
                r.is_name   = was_name;
                r.data      = b;
                r.last      = (p_left == 0);
                return 1'b1;
            end
            default: begin
                if (eob) p_phase = hpbp_pkg::PH_IDLE;
                else p_phase = hpbp_pkg::PH_DRAIN;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic longint unsigned rand_int(int nbits);
        longint unsigned top;
        top = (64'd1 << nbits) - 1;
        case ($urandom_range(0, 19))
            0:          return 0;
            1:          return IntMax - $urandom_range(0, 2);
            2:          return IntMax + 1 + $urandom;
            3:          return $urandom_range(0, 1 << 21);
            4, 5, 6, 7: return top + $urandom_range(0, 400);
            default:    return $urandom_range(1, 32'(top - 1));
        endcase
    endfunction

    // Prefix integer, sometimes with redundant zero continuation octets.
    function automatic void put_int(logic [7:0] pfx, int nbits, longint unsigned v);
        longint unsigned top;
        int              pad;
        top = (64'd1 << nbits) - 1;
        if (v < top) begin
            blk_q.push_back(pfx | v[7:0]);
            return;
        end
        blk_q.push_back(pfx | top[7:0]);
        v -= top;
        while (v >= 128) begin
            blk_q.push_back({1'b1, v[6:0]});
            v >>= 7;
        end
        pad = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 5) : 0;
        if (pad == 0) begin
            blk_q.push_back({1'b0, v[6:0]});
        end else begin
            blk_q.push_back({1'b1, v[6:0]});
            repeat (pad - 1) blk_q.push_back(8'h80);
            blk_q.push_back(8'h00);
        end
    endfunction

    function automatic void put_str();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 6);
        put_int({1'($urandom_range(0, 1)), 7'b0}, 7, len);
        repeat (len) blk_q.push_back(8'($urandom));
    endfunction

    function automatic void put_literal(logic [7:0] pfx, int nbits);
        longint unsigned idx;
        idx = ($urandom_range(0, 2) == 0) ? 0 : rand_int(nbits);
        put_int(pfx, nbits, idx);
        if (idx == 0) put_str();
        put_str();
    endfunction

    function automatic void add_block();
        int cut;
        blk_q.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_int(PfxIndexed, 7, rand_int(7));
                4, 5:       put_literal(PfxIncr, 6);
                6:          put_literal(PfxWithout, 4);
                7:          put_literal(PfxNever, 4);
                default:    put_int(PfxSize, 5, rand_int(5));
            endcase
        end
        case ($urandom_range(0, 19))
            0, 1: begin
                cut = $urandom_range(1, blk_q.size());
                while (blk_q.size() > cut) void'(blk_q.pop_back());
            end
            2: begin
                blk_q.delete();
                repeat ($urandom_range(1, 8)) blk_q.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (blk_q[i]) feed_q.push_back('{blk_q[i], i == blk_q.size() - 1, 1'b0, '0});
        blocks++;
    endfunction

    function automatic string show_event(hpbp_pkg::result_t e);
        return $sformatf("ev=%0d val=%0d kind=%0d huff=%0b name=%0b data=%02h last=%0b done=%0b",
                         e.ev, e.value, e.repr_kind, e.huff, e.is_name, e.data, e.last, e.done);
    endfunction

    always @(posedge aclk) begin
        hpbp_pkg::result_t got;
        hpbp_pkg::result_t want;
        hpbp_pkg::result_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_event_res, m_value, m_repr_kind, m_huffman_flag, m_is_name,
                       m_data_byte, m_last_of_string, m_block_done};
                ev_seen[got.ev]++;
                checked++;
                if (event_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected event: %s", show_event(got));
                end else begin
                    want = event_q.pop_front();
                    if (got.ev !== want.ev || got.value !== want.value ||
                        got.repr_kind !== want.repr_kind || got.huff !== want.huff ||
                        got.is_name !== want.is_name || got.data !== want.data ||
                        got.last !== want.last || got.done !== want.done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %s\n          actual   %s",
                                     show_event(want), show_event(got));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (parse_octet(s_byte_in, s_end_of_block, pred) && !pin_now)
                    event_q.push_back(pred);
                if (pin_now) event_q.push_back(pin_res);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : receiver
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent >= 500) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    initial begin : sender
        int i;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_byte_in      <= '0;
        s_end_of_block <= 1'b0;
        pin_now        <= 1'b0;
        pin_res        <= '0;
        foreach (directed_rows[k])
            feed_q.push_back('{directed_rows[k].b, directed_rows[k].eob, directed_rows[k].pinned,
                               ev_pack(directed_rows[k].ev, directed_rows[k].val,
                                       directed_rows[k].eob)});
        while (feed_q.size() < NumOctets) add_block();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (i = 0; i < feed_q.size(); i++) begin
            if (i == 1400) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (event_q.size() != 0);
            end
            while (!calm && $urandom_range(0, 99) < 23) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid        <= 1'b1;
            s_byte_in      <= feed_q[i].b;
            s_end_of_block <= feed_q[i].eob;
            pin_now        <= feed_q[i].pinned;
            pin_res        <= feed_q[i].res;
            do @(posedge aclk); while (!s_ready);
            sent++;
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (event_q.size() != 0);
        repeat (8) @(posedge aclk);
        $display("covered %0d octets in %0d random blocks plus a directed table;",
                 sent, blocks);
        $display("%0d events (indexed %0d, literal %0d, string %0d, byte %0d, size %0d, error %0d), %0d bad",
                 checked, ev_seen[hpbp_pkg::EV_INDEXED], ev_seen[hpbp_pkg::EV_LITERAL],
                 ev_seen[hpbp_pkg::EV_STR_START], ev_seen[hpbp_pkg::EV_STR_BYTE],
                 ev_seen[hpbp_pkg::EV_SIZE], ev_seen[hpbp_pkg::EV_ERROR], mismatches);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/hpbp_pkg.sv
design/hpbp_step.sv
design/hpack_header_block_parser_unit.sv
tb/tb_hpack_header_block_parser_unit.sv
